// ----- hw/rtl/pipt_pkg.sv -----
`timescale 1ns / 1ps
package pipt_pkg;

  localparam int COORD_BITS   = 16;
  localparam int MAX_VERTICES = 16;
  localparam int MIN_VERTICES = 3;
  localparam int INDEX_BITS   = 4;
  localparam int COUNT_BITS   = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

endpackage

// ----- hw/rtl/pipt_channels.sv -----
`timescale 1ns / 1ps
interface pipt_req_if #(
  parameter int COORD_BITS = pipt_pkg::COORD_BITS
);
  logic                                  valid;
  logic                                  ready;
  logic                                  op;
  logic [pipt_pkg::INDEX_BITS-1:0]       vertex_index;
  logic signed [COORD_BITS-1:0]          x;
  logic signed [COORD_BITS-1:0]          y;

  modport source (output valid, op, vertex_index, x, y, input ready);
  modport sink (input valid, op, vertex_index, x, y, output ready);
endinterface

interface pipt_rsp_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic on_vertex;

  modport source (output valid, inside_res, on_vertex, input ready);
  modport sink (input valid, inside_res, on_vertex, output ready);
endinterface

// ----- hw/rtl/point_in_polygon_test_core.sv -----
`timescale 1ns / 1ps
// a vertex write gives no result word; a query gives its word once every edge of the
// polygon in use has left the pipeline and the output is free
// throughput: one query at a time, set by the single read
// port of the vertex memory walking one vertex per cycle through a 3-stage edge test
// reset: control is cleared and vertex count set to 3, vertex memory is undefined until written
module point_in_polygon_test_core #(
  parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES,
  parameter int COORD_BITS   = pipt_pkg::COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pipt_pkg::COUNT_BITS-1:0] cfg_wdata,
  pipt_req_if.sink                        req,
  pipt_rsp_if.source                      rsp
);

  localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int SW    = PW + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]                    state;
  logic [pipt_pkg::COUNT_BITS-1:0] vertex_count;
  logic [CNT_W-1:0]              n_clamped;
  logic [CNT_W-1:0]              n_used;
  logic [CNT_W-1:0]              rd_cnt;
  logic [IDX_W-1:0]              rd_addr;
  logic [IDX_W-1:0]              wr_addr;
  logic                          wr_ok;
  logic                          accept;
  logic                          pipe_empty;
  logic                          load_out;

  logic signed [COORD_BITS-1:0]  mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0]  mem_y [MAX_VERTICES];
  logic signed [COORD_BITS-1:0]  rd_x, rd_y;
  logic signed [COORD_BITS-1:0]  prev_x, prev_y;
  logic signed [COORD_BITS-1:0]  px, py;
  logic                          rd_valid, rd_first;

  logic signed [COORD_BITS-1:0]  lo_x, lo_y, hi_x, hi_y;
  logic signed [DW-1:0]          e_a, e_b, e_c, e_d;
  logic                          e_valid, e_cond;
  logic signed [PW-1:0]          m_p1, m_p2;
  logic                          m_valid, m_cond;
  logic signed [SW-1:0]          m_sum;
  logic                          match, parity;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign pipe_empty = !rd_valid && !e_valid && !m_valid;
  assign load_out   = (state == S_FLUSH) && pipe_empty && (!rsp.valid || rsp.ready);

  always_comb begin
    if (vertex_count < pipt_pkg::COUNT_BITS'(pipt_pkg::MIN_VERTICES)) begin
      n_clamped = CNT_W'(pipt_pkg::MIN_VERTICES);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_clamped = CNT_W'(MAX_VERTICES);
    end else begin
      n_clamped = CNT_W'(vertex_count);
    end
  end

  // the walk reads vertices 0..n-1, then vertex 0 again for the closing edge
  assign rd_addr = (rd_cnt == n_used) ? '0 : rd_cnt[IDX_W-1:0];
  assign wr_addr = IDX_W'(req.vertex_index);
  assign wr_ok   = 32'(req.vertex_index) < MAX_VERTICES;

  always_ff @(posedge clk) begin
    if (accept && req.op == pipt_pkg::OP_WRITE && wr_ok) begin
      mem_x[wr_addr] <= req.x;
      mem_y[wr_addr] <= req.y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= pipt_pkg::COUNT_BITS'(pipt_pkg::MIN_VERTICES);
      rd_valid     <= 1'b0;
      e_valid      <= 1'b0;
      m_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_wdata;
      end
      rd_valid <= (state == S_WALK);
      e_valid  <= rd_valid && !rd_first;
      m_valid  <= e_valid;
      unique case (state)
        S_IDLE: begin
          if (accept && req.op == pipt_pkg::OP_TEST) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (rd_cnt == n_used) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px     <= req.x;
      py     <= req.y;
      n_used <= n_clamped;
      rd_cnt <= '0;
    end else if (state == S_WALK) begin
      rd_cnt <= rd_cnt + CNT_W'(1);
    end
    rd_first <= (state == S_WALK) && (rd_cnt == '0);
    if (rd_valid) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
  end

  // edge from the previous vertex to the one just read
  always_comb begin
    if (prev_y < rd_y) begin
      lo_x = prev_x;
      lo_y = prev_y;
      hi_x = rd_x;
      hi_y = rd_y;
    end else begin
      lo_x = rd_x;
      lo_y = rd_y;
      hi_x = prev_x;
      hi_y = prev_y;
    end
  end

  always_ff @(posedge clk) begin
    e_cond <= (lo_y < py) && (py <= hi_y);
    e_a    <= DW'(lo_x) - DW'(px);
    e_b    <= DW'(hi_y) - DW'(lo_y);
    e_c    <= DW'(py) - DW'(lo_y);
    e_d    <= DW'(hi_x) - DW'(lo_x);
    m_cond <= e_cond;
    m_p1   <= e_a * e_b;
    m_p2   <= e_c * e_d;
  end

  assign m_sum = SW'(m_p1) + SW'(m_p2);

  always_ff @(posedge clk) begin
    if (accept) begin
      match  <= 1'b0;
      parity <= 1'b0;
    end else begin
      if (rd_valid && rd_x == px && rd_y == py) begin
        match <= 1'b1;
      end
      if (m_valid && m_cond && !m_sum[SW-1]) begin
        parity <= ~parity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.inside_res <= match || parity;
      rsp.on_vertex  <= match;
    end
  end

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (rd_cnt <= n_used))
    else $error("vertex walk ran past the closing edge");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!rd_valid && !e_valid && !m_valid))
    else $error("edge pipeline busy while idle");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) ##1 (state == S_IDLE) |-> rsp.valid)
    else $error("query finished without a result word");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == pipt_pkg::OP_WRITE && !rsp.valid) |=> !rsp.valid)
    else $error("vertex write produced a result word");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic                                   op;
    logic [pipt_pkg::INDEX_BITS-1:0]        vertex_index;
    logic signed [pipt_pkg::COORD_BITS-1:0] x;
    logic signed [pipt_pkg::COORD_BITS-1:0] y;
  } req_word_t;

  typedef struct packed {
    logic inside_res;
    logic on_vertex;
  } verdict_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [pipt_pkg::COUNT_BITS-1:0] cfg_wdata;

  pipt_req_if req ();
  pipt_rsp_if rsp ();

  point_in_polygon_test_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  req_word_t word_q[$];
  verdict_t  pending_verdicts[$];

  logic signed [pipt_pkg::COORD_BITS-1:0] vert_x_model[pipt_pkg::MAX_VERTICES];
  logic signed [pipt_pkg::COORD_BITS-1:0] vert_y_model[pipt_pkg::MAX_VERTICES];
  int count_model = pipt_pkg::MIN_VERTICES;

  int gen_x[pipt_pkg::MAX_VERTICES];
  int gen_y[pipt_pkg::MAX_VERTICES];

  int issued_words = 0;
  int taken_words = 0;
  int errors = 0;
  int n_queries = 0;
  int n_inside = 0;
  int n_on_vertex = 0;
  int n_writes = 0;
  int n_settings = 0;
  bit quiet_phase = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic int clamp_count(input int v);
    if (v < pipt_pkg::MIN_VERTICES) return pipt_pkg::MIN_VERTICES;
    if (v > pipt_pkg::MAX_VERTICES) return pipt_pkg::MAX_VERTICES;
    return v;
  endfunction

  // ray cast to the right, exact cross product test per edge
  function automatic verdict_t judge_point(
    input logic signed [pipt_pkg::COORD_BITS-1:0] qx,
    input logic signed [pipt_pkg::COORD_BITS-1:0] qy
  );
    int n;
    int j;
    longint px, py, x1, y1, x2, y2, xl, yl, xh, yh, lhs;
    bit parity;
    verdict_t v;
    n = clamp_count(count_model);
    px = qx;
    py = qy;
    parity = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (vert_x_model[i] == qx && vert_y_model[i] == qy) begin
        v.inside_res = 1'b1;
        v.on_vertex = 1'b1;
        return v;
      end
    end
    for (int i = 0; i < n; i++) begin
      j = (i + 1 < n) ? i + 1 : 0;
      x1 = vert_x_model[i];
      y1 = vert_y_model[i];
      x2 = vert_x_model[j];
      y2 = vert_y_model[j];
      if (y1 < y2) begin
        xl = x1; yl = y1; xh = x2; yh = y2;
      end else begin
        xl = x2; yl = y2; xh = x1; yh = y1;
      end
      if (yl < py && py <= yh) begin
        lhs = (xl - px) * (yh - yl) + (py - yl) * (xh - xl);
        if (lhs >= 0) parity = ~parity;
      end
    end
    v.inside_res = parity;
    v.on_vertex = 1'b0;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int rand_coord(input int scale);
    int r;
    case (scale)
      0: begin
        r = $urandom_range(0, 40);
        return r - 20;
      end
      1: begin
        r = $urandom_range(0, 4000);
        return r - 2000;
      end
      2: begin
        r = $urandom_range(0, 65535);
        return r - 32768;
      end
      default: begin
        r = $urandom_range(0, 3);
        case (r)
          0: return -32768;
          1: return 32767;
          2: return -32767;
          default: return 32766;
        endcase
      end
    endcase
  endfunction

  task automatic push_write(input int idx, input int x, input int y);
    req_word_t w;
    w.op = pipt_pkg::OP_WRITE;
    w.vertex_index = idx[pipt_pkg::INDEX_BITS-1:0];
    w.x = x[pipt_pkg::COORD_BITS-1:0];
    w.y = y[pipt_pkg::COORD_BITS-1:0];
    gen_x[idx % pipt_pkg::MAX_VERTICES] = $signed(w.x);
    gen_y[idx % pipt_pkg::MAX_VERTICES] = $signed(w.y);
    word_q = {word_q, w};
  endtask

  task automatic push_query(input int x, input int y);
    req_word_t w;
    int idx;
    idx = $urandom_range(0, 15);
    w.op = pipt_pkg::OP_TEST;
    w.vertex_index = idx[pipt_pkg::INDEX_BITS-1:0];
    w.x = x[pipt_pkg::COORD_BITS-1:0];
    w.y = y[pipt_pkg::COORD_BITS-1:0];
    word_q = {word_q, w};
  endtask

  task automatic drain_block();
    while (word_q.size() != 0 || req.valid || pending_verdicts.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[pipt_pkg::COUNT_BITS-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    count_model = v;
    n_settings++;
  endtask

  // request driver
  int req_gap = 0;
  req_word_t req_next;
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req_gap = 0;
    end else if (!(req.valid && taken_words != issued_words)) begin
      if (req.valid) req_gap = pick_gap();
      if (req_gap > 0 || word_q.size() == 0) begin
        if (req_gap > 0) req_gap--;
        req.valid <= 1'b0;
      end else begin
        req_next = word_q.pop_front();
        req.op <= req_next.op;
        req.vertex_index <= req_next.vertex_index;
        req.x <= req_next.x;
        req.y <= req_next.y;
        req.valid <= 1'b1;
        issued_words++;
      end
    end
  end

  // response ready with random stalls
  int rsp_stall = 0;
  always @(negedge clk) begin
    int r;
    if (quiet_phase) begin
      rsp_stall = 0;
      rsp.ready <= 1'b1;
    end else if (rsp_stall > 0) begin
      rsp_stall--;
      rsp.ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 20) rsp_stall = $urandom_range(1, 3);
      else if (r < 23) rsp_stall = $urandom_range(10, 40);
      rsp.ready <= (rsp_stall == 0);
      if (rsp_stall > 0) rsp_stall--;
    end
  end

  // monitor: predict on accepted requests, check accepted responses
  verdict_t want;
  verdict_t got;
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) begin
        taken_words++;
        if (req.op == pipt_pkg::OP_WRITE) begin
          vert_x_model[req.vertex_index] = req.x;
          vert_y_model[req.vertex_index] = req.y;
          n_writes++;
        end else begin
          want = judge_point(req.x, req.y);
          pending_verdicts = {pending_verdicts, want};
          n_queries++;
          if (want.inside_res) n_inside++;
          if (want.on_vertex) n_on_vertex++;
        end
      end
      if (rsp.valid && rsp.ready) begin
        got.inside_res = rsp.inside_res;
        got.on_vertex = rsp.on_vertex;
        if (pending_verdicts.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: inside_res=%b on_vertex=%b",
                     got.inside_res, got.on_vertex);
        end else begin
          want = pending_verdicts.pop_front();
          if (got.inside_res !== want.inside_res || got.on_vertex !== want.on_vertex) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected inside_res=%b on_vertex=%b, got %b %b",
                       want.inside_res, want.on_vertex, got.inside_res, got.on_vertex);
          end
        end
      end
    end
  end

  int count_extremes[8] = '{0, 3, 16, 31, 2, 17, 1, 4};

  initial begin
    int random_words;
    int phase;
    int cfg_val;
    int n_used;
    int scale;
    int nq;
    int kind;
    int k;
    int j;
    int x;
    int y;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.op = pipt_pkg::OP_WRITE;
    req.vertex_index = '0;
    req.x = '0;
    req.y = '0;
    rsp.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // small triangle under the reset vertex count
    push_write(0, 0, 0);
    push_write(1, 10, 0);
    push_write(2, 0, 10);
    push_query(0, 0);
    push_query(2, 2);
    push_query(20, 20);
    push_query(5, 0);
    push_query(0, 5);
    push_query(5, 5);
    push_query(-1, 5);
    push_query(10, 0);
    push_write(15, -32768, -32768);
    // triangle spanning the full coordinate range
    push_write(0, -32768, -32768);
    push_write(1, 32767, -32768);
    push_write(2, 0, 32767);
    push_query(0, 0);
    push_query(-32768, -32768);
    push_query(32767, 32767);
    push_query(-32768, 32767);
    push_query(0, -32768);
    push_query(32767, -32767);
    push_query(0, 32767);
    push_query(-1, 32766);

    random_words = 0;
    phase = 0;
    while (random_words < 900) begin
      drain_block();
      if (phase < 8) begin
        cfg_val = count_extremes[phase];
      end else if ($urandom_range(0, 9) == 0) begin
        cfg_val = $urandom_range(0, 31);
      end else begin
        cfg_val = $urandom_range(pipt_pkg::MIN_VERTICES, pipt_pkg::MAX_VERTICES);
      end
      quiet_phase = ($urandom_range(0, 3) == 0);
      set_vertex_count(cfg_val);
      n_used = clamp_count(cfg_val);
      k = $urandom_range(0, 9);
      scale = (k < 5) ? 0 : (k < 8) ? 1 : (k < 9) ? 2 : 3;

      for (int i = 0; i < n_used; i++) begin
        x = rand_coord(scale);
        y = rand_coord(scale);
        if (i > 0) begin
          k = $urandom_range(0, 11);
          if (k < 2) y = gen_y[i-1];
          else if (k == 2) begin
            x = gen_x[i-1];
            y = gen_y[i-1];
          end
        end
        push_write(i, x, y);
        random_words++;
      end

      nq = $urandom_range(8, 24);
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(0, 9) == 0) begin
          k = $urandom_range(0, 15);
          push_write(k, rand_coord($urandom_range(0, 2)), rand_coord($urandom_range(0, 2)));
        end else begin
          kind = $urandom_range(0, 9);
          k = $urandom_range(0, n_used - 1);
          j = (k + 1 < n_used) ? k + 1 : 0;
          case (kind)
            0, 1: begin
              x = gen_x[k];
              y = gen_y[k];
            end
            2: begin
              x = gen_x[k] + rand_coord(0);
              y = gen_y[k];
            end
            3: begin
              x = (gen_x[k] + gen_x[j]) >>> 1;
              y = (gen_y[k] + gen_y[j]) >>> 1;
            end
            7: begin
              x = gen_x[k] + $urandom_range(0, 2) - 1;
              y = gen_y[k] + $urandom_range(0, 2) - 1;
            end
            8: begin
              x = rand_coord(2);
              y = rand_coord(2);
            end
            9: begin
              x = rand_coord(0);
              y = rand_coord(0);
            end
            default: begin
              x = rand_coord(scale);
              y = rand_coord(scale);
            end
          endcase
          push_query(x, y);
        end
        random_words++;
      end
      phase++;
    end

    quiet_phase = 0;
    drain_block();
    $display("%0d phases, %0d vertex-count settings, %0d vertex writes", phase, n_settings,
             n_writes);
    $display("%0d queries checked: %0d inside, %0d on a vertex, %0d failures", n_queries,
             n_inside, n_on_vertex, errors);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pipt_pkg.sv
hw/rtl/pipt_channels.sv
hw/rtl/point_in_polygon_test_core.sv
tb/tb.sv
